### src/cob_pkg.sv
// ----------------------------------------------------------------------------
// cob_pkg
// Shared types and codes for the clipped OR-blitter: command codes, register
// indexes, datapath operations and the controller/datapath handshake structs.
// ----------------------------------------------------------------------------
package cob_pkg;

    // Internal signed width for corner and size arithmetic during clipping
    localparam int CW = 12;

    typedef enum logic [1:0] {
        CMD_LOAD_SRC = 2'd0,
        CMD_LOAD_DST = 2'd1,
        CMD_READ     = 2'd2,
        CMD_BLIT     = 2'd3
    } cmd_code_t;

    typedef enum logic [1:0] {
        CFG_SRC_W = 2'd0,
        CFG_SRC_H = 2'd1,
        CFG_DST_W = 2'd2,
        CFG_DST_H = 2'd3
    } cfg_idx_t;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_CLEAR,
        DP_CAPTURE,
        DP_ACCESS,
        DP_CLIP_SRC,
        DP_CLIP_DST,
        DP_LIM_SRC,
        DP_LIM_DST,
        DP_SETUP,
        DP_WALK,
        DP_RESULT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic new_blit;
        logic rect_empty;
        logic walk_last;
        logic out_free;
    } dp_status_t;

endpackage

### src/cob_ctrl.sv
// ----------------------------------------------------------------------------
// cob_ctrl
// Sequencer for the blitter: clearing pass after reset, single-pixel accesses,
// the four clipping steps, the rectangle walk and the result hand-off.
// ----------------------------------------------------------------------------
module cob_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    output cob_pkg::dp_cmd_t    cmd,
    input  cob_pkg::dp_status_t status
);
    import cob_pkg::*;

    typedef enum logic [9:0] {
        ST_CLEAR    = 10'b00_0000_0001,
        ST_IDLE     = 10'b00_0000_0010,
        ST_ACCESS   = 10'b00_0000_0100,
        ST_CLIP_SRC = 10'b00_0000_1000,
        ST_CLIP_DST = 10'b00_0001_0000,
        ST_LIM_SRC  = 10'b00_0010_0000,
        ST_LIM_DST  = 10'b00_0100_0000,
        ST_SETUP    = 10'b00_1000_0000,
        ST_WALK     = 10'b01_0000_0000,
        ST_RESULT   = 10'b10_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = DP_NOP;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.op = DP_CLEAR;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.op     = DP_CAPTURE;
                    state_next = status.new_blit ? ST_CLIP_SRC : ST_ACCESS;
                end
            end
            ST_ACCESS:
            begin
                cmd.op     = DP_ACCESS;
                state_next = ST_RESULT;
            end
            ST_CLIP_SRC:
            begin
                cmd.op     = DP_CLIP_SRC;
                state_next = ST_CLIP_DST;
            end
            ST_CLIP_DST:
            begin
                cmd.op     = DP_CLIP_DST;
                state_next = ST_LIM_SRC;
            end
            ST_LIM_SRC:
            begin
                cmd.op     = DP_LIM_SRC;
                state_next = ST_LIM_DST;
            end
            ST_LIM_DST:
            begin
                cmd.op     = DP_LIM_DST;
                state_next = ST_SETUP;
            end
            ST_SETUP:
            begin
                cmd.op     = DP_SETUP;
                state_next = status.rect_empty ? ST_RESULT : ST_WALK;
            end
            ST_WALK:
            begin
                cmd.op = DP_WALK;
                if (status.walk_last)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                // hold until the output register can take the item
                if (status.out_free)
                begin
                    cmd.op     = DP_RESULT;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign item_stall = (state_reg != ST_IDLE);

    a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_CLEAR) |=> (state_reg != ST_CLEAR))
        else $error("clearing pass re-entered");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RESULT && !status.out_free) |=> (state_reg == ST_RESULT))
        else $error("result dropped while output register busy");

    a_walk_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == DP_WALK) |=> (state_reg == ST_WALK || state_reg == ST_RESULT))
        else $error("walk left to an unexpected state");

endmodule

### src/cob_datapath.sv
// ----------------------------------------------------------------------------
// cob_datapath
// Screen memories, size registers, clipping arithmetic, rectangle address
// walk with OR write-back, and the output register.
// ----------------------------------------------------------------------------
module cob_datapath #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  cob_pkg::dp_cmd_t    cmd,
    output cob_pkg::dp_status_t status,
    input  logic [1:0]          command,
    input  logic signed [8:0]   pos_x,
    input  logic signed [8:0]   pos_y,
    input  logic [7:0]          pixel_value,
    input  logic signed [8:0]   target_x,
    input  logic signed [8:0]   target_y,
    input  logic signed [8:0]   blit_width,
    input  logic signed [8:0]   blit_height,
    input  logic                cfg_valid,
    input  logic [1:0]          cfg_index,
    input  logic [6:0]          cfg_data,
    input  logic                result_stall,
    output logic                result_valid,
    output logic [7:0]          read_pixel,
    output logic [12:0]         pixels_written
);
    import cob_pkg::*;

    localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int W_CLAMP = (MAX_WIDTH > 127) ? 127 : MAX_WIDTH;
    localparam int H_CLAMP = (MAX_HEIGHT > 127) ? 127 : MAX_HEIGHT;

    // Size registers
    logic [6:0] src_w_reg, src_h_reg, dst_w_reg, dst_h_reg;
    logic [6:0] sw_eff, sh_eff, dw_eff, dh_eff;
    logic signed [CW-1:0] sw_s, sh_s, dw_s, dh_s;

    // Captured item and clipping state
    cmd_code_t            cmd_reg, cmd_next;
    logic [7:0]           val_reg, val_next;
    logic signed [CW-1:0] fx_reg, fx_next, fy_reg, fy_next;
    logic signed [CW-1:0] tx_reg, tx_next, ty_reg, ty_next;
    logic signed [CW-1:0] w_reg, w_next, h_reg, h_next;

    // Walk state
    logic [AW-1:0] src_row_reg, src_row_next, src_addr_reg, src_addr_next;
    logic [AW-1:0] dst_row_reg, dst_row_next, dst_addr_reg, dst_addr_next;
    logic [6:0]    col_reg, col_next, row_reg, row_next;
    logic [12:0]   count_reg, count_next;
    logic [6:0]    w7, h7;
    logic [13:0]   s_prod, d_prod, area;
    logic [AW-1:0] s_base, d_base;

    // Single-pixel access
    logic                 acc_in;
    logic                 acc_hit_reg;
    logic [6:0]           acc_stride;
    logic signed [CW-1:0] acc_w_s, acc_h_s;
    logic [13:0]          acc_prod;
    logic [AW-1:0]        acc_addr;

    // Memories and their ports
    logic [7:0]    src_mem [DEPTH];
    logic [7:0]    dst_mem [DEPTH];
    logic          src_we, dst_we, src_re, dst_re;
    logic [AW-1:0] src_waddr, dst_waddr, dst_raddr;
    logic [7:0]    src_wdata, dst_wdata;
    logic [7:0]    src_rdata_reg, dst_rdata_reg;

    logic [AW-1:0] clr_cnt_reg;
    logic          wb_valid_reg;
    logic [AW-1:0] wb_addr_reg;

    logic          result_valid_reg;
    logic [7:0]    read_pixel_reg;
    logic [12:0]   pixels_written_reg;

    // Sizes above the screen maximum act as the maximum
    assign sw_eff = (src_w_reg > 7'(W_CLAMP)) ? 7'(W_CLAMP) : src_w_reg;
    assign sh_eff = (src_h_reg > 7'(H_CLAMP)) ? 7'(H_CLAMP) : src_h_reg;
    assign dw_eff = (dst_w_reg > 7'(W_CLAMP)) ? 7'(W_CLAMP) : dst_w_reg;
    assign dh_eff = (dst_h_reg > 7'(H_CLAMP)) ? 7'(H_CLAMP) : dst_h_reg;
    assign sw_s   = signed'(CW'(sw_eff));
    assign sh_s   = signed'(CW'(sh_eff));
    assign dw_s   = signed'(CW'(dw_eff));
    assign dh_s   = signed'(CW'(dh_eff));

    assign w7 = w_reg[6:0];
    assign h7 = h_reg[6:0];

    // Start addresses and area; only meaningful for a non-empty rectangle,
    // where every corner and size is below 128
    assign s_prod = fy_reg[6:0] * sw_eff;
    assign d_prod = ty_reg[6:0] * dw_eff;
    assign area   = w7 * h7;
    assign s_base = AW'(s_prod + 14'(fx_reg[6:0]));
    assign d_base = AW'(d_prod + 14'(tx_reg[6:0]));

    assign acc_w_s    = (cmd_reg == CMD_LOAD_SRC) ? sw_s : dw_s;
    assign acc_h_s    = (cmd_reg == CMD_LOAD_SRC) ? sh_s : dh_s;
    assign acc_stride = (cmd_reg == CMD_LOAD_SRC) ? sw_eff : dw_eff;
    assign acc_in     = !fx_reg[CW-1] && !fy_reg[CW-1]
                        && (fx_reg < acc_w_s) && (fy_reg < acc_h_s);
    assign acc_prod   = fy_reg[6:0] * acc_stride;
    assign acc_addr   = AW'(acc_prod + 14'(fx_reg[6:0]));

    always_comb
    begin
        cmd_next      = cmd_reg;
        val_next      = val_reg;
        fx_next       = fx_reg;
        fy_next       = fy_reg;
        tx_next       = tx_reg;
        ty_next       = ty_reg;
        w_next        = w_reg;
        h_next        = h_reg;
        src_row_next  = src_row_reg;
        src_addr_next = src_addr_reg;
        dst_row_next  = dst_row_reg;
        dst_addr_next = dst_addr_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        count_next    = count_reg;
        unique case (cmd.op)
            DP_CAPTURE:
            begin
                cmd_next = cmd_code_t'(command);
                val_next = pixel_value;
                fx_next  = CW'(pos_x);
                fy_next  = CW'(pos_y);
                tx_next  = CW'(target_x);
                ty_next  = CW'(target_y);
                w_next   = CW'(blit_width);
                h_next   = CW'(blit_height);
            end
            DP_CLIP_SRC:
            begin
                // negative source corner: move the destination, shrink the size
                if (fx_reg[CW-1])
                begin
                    tx_next = tx_reg - fx_reg;
                    w_next  = w_reg + fx_reg;
                    fx_next = '0;
                end
                if (fy_reg[CW-1])
                begin
                    ty_next = ty_reg - fy_reg;
                    h_next  = h_reg + fy_reg;
                    fy_next = '0;
                end
            end
            DP_CLIP_DST:
            begin
                if (tx_reg[CW-1])
                begin
                    fx_next = fx_reg - tx_reg;
                    w_next  = w_reg + tx_reg;
                    tx_next = '0;
                end
                if (ty_reg[CW-1])
                begin
                    fy_next = fy_reg - ty_reg;
                    h_next  = h_reg + ty_reg;
                    ty_next = '0;
                end
            end
            DP_LIM_SRC:
            begin
                if (w_reg > sw_s - fx_reg)
                begin
                    w_next = sw_s - fx_reg;
                end
                if (h_reg > sh_s - fy_reg)
                begin
                    h_next = sh_s - fy_reg;
                end
            end
            DP_LIM_DST:
            begin
                if (w_reg > dw_s - tx_reg)
                begin
                    w_next = dw_s - tx_reg;
                end
                if (h_reg > dh_s - ty_reg)
                begin
                    h_next = dh_s - ty_reg;
                end
            end
            DP_SETUP:
            begin
                src_row_next  = s_base;
                src_addr_next = s_base;
                dst_row_next  = d_base;
                dst_addr_next = d_base;
                col_next      = '0;
                row_next      = '0;
                count_next    = status.rect_empty ? 13'd0 : area[12:0];
            end
            DP_WALK:
            begin
                if (col_reg == w7 - 7'd1)
                begin
                    // advance to the next row
                    col_next      = '0;
                    row_next      = row_reg + 7'd1;
                    src_row_next  = src_row_reg + AW'(sw_eff);
                    src_addr_next = src_row_reg + AW'(sw_eff);
                    dst_row_next  = dst_row_reg + AW'(dw_eff);
                    dst_addr_next = dst_row_reg + AW'(dw_eff);
                end
                else
                begin
                    col_next      = col_reg + 7'd1;
                    src_addr_next = src_addr_reg + AW'(1);
                    dst_addr_next = dst_addr_reg + AW'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    // Memory port selection
    always_comb
    begin
        src_we    = 1'b0;
        src_waddr = acc_addr;
        src_wdata = val_reg;
        dst_we    = 1'b0;
        dst_waddr = acc_addr;
        dst_wdata = val_reg;
        if (cmd.op == DP_CLEAR)
        begin
            src_we    = 1'b1;
            src_waddr = clr_cnt_reg;
            src_wdata = '0;
            dst_we    = 1'b1;
            dst_waddr = clr_cnt_reg;
            dst_wdata = '0;
        end
        else if (wb_valid_reg)
        begin
            dst_we    = 1'b1;
            dst_waddr = wb_addr_reg;
            dst_wdata = dst_rdata_reg | src_rdata_reg;
        end
        else if (cmd.op == DP_ACCESS && acc_in)
        begin
            src_we = (cmd_reg == CMD_LOAD_SRC);
            dst_we = (cmd_reg == CMD_LOAD_DST);
        end
    end

    assign src_re    = (cmd.op == DP_WALK);
    assign dst_re    = (cmd.op == DP_WALK) || (cmd.op == DP_ACCESS);
    assign dst_raddr = (cmd.op == DP_WALK) ? dst_addr_reg : acc_addr;

    always_ff @(posedge clk)
    begin
        if (src_we)
        begin
            src_mem[src_waddr] <= src_wdata;
        end
        if (src_re)
        begin
            src_rdata_reg <= src_mem[src_addr_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (dst_we)
        begin
            dst_mem[dst_waddr] <= dst_wdata;
        end
        if (dst_re)
        begin
            dst_rdata_reg <= dst_mem[dst_raddr];
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_w_reg        <= 7'd64;
            src_h_reg        <= 7'd64;
            dst_w_reg        <= 7'd64;
            dst_h_reg        <= 7'd64;
            clr_cnt_reg      <= '0;
            wb_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_SRC_W: src_w_reg <= cfg_data;
                    CFG_SRC_H: src_h_reg <= cfg_data;
                    CFG_DST_W: dst_w_reg <= cfg_data;
                    CFG_DST_H: dst_h_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.op == DP_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            wb_valid_reg <= (cmd.op == DP_WALK);
            if (cmd.op == DP_RESULT)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        val_reg      <= val_next;
        fx_reg       <= fx_next;
        fy_reg       <= fy_next;
        tx_reg       <= tx_next;
        ty_reg       <= ty_next;
        w_reg        <= w_next;
        h_reg        <= h_next;
        src_row_reg  <= src_row_next;
        src_addr_reg <= src_addr_next;
        dst_row_reg  <= dst_row_next;
        dst_addr_reg <= dst_addr_next;
        col_reg      <= col_next;
        row_reg      <= row_next;
        count_reg    <= count_next;
        if (cmd.op == DP_WALK)
        begin
            wb_addr_reg <= dst_addr_reg;
        end
        if (cmd.op == DP_ACCESS)
        begin
            acc_hit_reg <= acc_in;
        end
        if (cmd.op == DP_RESULT)
        begin
            read_pixel_reg     <= (cmd_reg == CMD_READ && acc_hit_reg) ? dst_rdata_reg : 8'd0;
            pixels_written_reg <= (cmd_reg == CMD_BLIT) ? count_reg : 13'd0;
        end
    end

    assign status.clear_last = (clr_cnt_reg == AW'(DEPTH - 1));
    assign status.new_blit   = (cmd_code_t'(command) == CMD_BLIT);
    assign status.rect_empty = (w_reg <= 0) || (h_reg <= 0);
    assign status.walk_last  = (col_reg == w7 - 7'd1) && (row_reg == h7 - 7'd1);
    assign status.out_free   = !result_valid_reg || !result_stall;

    assign result_valid   = result_valid_reg;
    assign read_pixel     = read_pixel_reg;
    assign pixels_written = pixels_written_reg;

    a_wb_follows_walk: assert property (@(posedge clk) disable iff (!rst_n)
        wb_valid_reg |-> $past(cmd.op == DP_WALK))
        else $error("write-back without a walk read");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(cmd.op == DP_RESULT))
        else $error("result raised without a load");

    a_walk_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == DP_WALK) |-> (row_reg < h7 && col_reg < w7))
        else $error("walk outside the clipped rectangle");

endmodule

### src/clipped_or_blitter.sv
// ----------------------------------------------------------------------------
// clipped_or_blitter
// Two 8-bit screens with pixel load/read commands and a clipped OR-blit from
// the source screen into the destination screen.
// ----------------------------------------------------------------------------
// After reset both screens are swept to zero, one address per cycle, through
// all MAX_WIDTH * MAX_HEIGHT addresses (4096 by default); item_stall stays
// high during the sweep while size writes are taken as usual. One item is
// worked at a time. A pixel load or read goes from acceptance to the next
// acceptance through capture, one memory access and result. A blit goes
// through capture, four clipping steps and a set-up step, then, unless the
// clipped rectangle is empty, the rectangle walk, which reads both screens
// and writes one ORed destination pixel per cycle through the single write
// port of the destination memory, and then the result. A finished result
// sits in the output register while the next item is accepted.
module clipped_or_blitter #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  logic [1:0]        command,
    input  logic signed [8:0] pos_x,
    input  logic signed [8:0] pos_y,
    input  logic [7:0]        pixel_value,
    input  logic signed [8:0] target_x,
    input  logic signed [8:0] target_y,
    input  logic signed [8:0] blit_width,
    input  logic signed [8:0] blit_height,
    output logic              result_valid,
    input  logic              result_stall,
    output logic [7:0]        read_pixel,
    output logic [12:0]       pixels_written,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [6:0]        cfg_data
);
    import cob_pkg::*;

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    // size registers take a write in any cycle
    assign cfg_ready = 1'b1;

    cob_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .cmd        (dp_cmd),
        .status     (dp_status)
    );

    cob_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (dp_cmd),
        .status         (dp_status),
        .command        (command),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .pixel_value    (pixel_value),
        .target_x       (target_x),
        .target_y       (target_y),
        .blit_width     (blit_width),
        .blit_height    (blit_height),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .result_stall   (result_stall),
        .result_valid   (result_valid),
        .read_pixel     (read_pixel),
        .pixels_written (pixels_written)
    );

endmodule

### dv/clipped_or_blitter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clipped_or_blitter_tb
// Drives pixel loads, reads and clipped OR-blits into the blitter under
// several screen sizes, keeps its own copy of both screens to work out each
// result, and compares every result item against the oldest expected one.
// ----------------------------------------------------------------------------
module clipped_or_blitter_tb;

    import cob_pkg::*;

    localparam int MAXW    = 64;
    localparam int MAXH    = 64;
    localparam int SCREEN  = MAXW * MAXH;
    localparam int N_PHASE = 7;

    typedef struct {
        cmd_code_t         cmd;
        logic signed [8:0] px;
        logic signed [8:0] py;
        logic [7:0]        val;
        logic signed [8:0] tx;
        logic signed [8:0] ty;
        logic signed [8:0] w;
        logic signed [8:0] h;
    } pix_item_t;

    typedef struct {
        logic [7:0]  rd;
        logic [12:0] count;
    } blit_result_t;

    logic              clk;
    logic              rst_n;
    logic              item_valid;
    logic              item_stall;
    logic [1:0]        command;
    logic signed [8:0] pos_x;
    logic signed [8:0] pos_y;
    logic [7:0]        pixel_value;
    logic signed [8:0] target_x;
    logic signed [8:0] target_y;
    logic signed [8:0] blit_width;
    logic signed [8:0] blit_height;
    logic              result_valid;
    logic              result_stall;
    logic [7:0]        read_pixel;
    logic [12:0]       pixels_written;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [1:0]        cfg_index;
    logic [6:0]        cfg_data;

    // Local copy of the block's state
    logic [7:0]   src_screen [SCREEN];
    logic [7:0]   dst_screen [SCREEN];
    logic [6:0]   size_reg [4];

    blit_result_t pending_results[$];
    blit_result_t want;
    int           fail_count;
    bit           idle_on;
    int           stall_left;

    clipped_or_blitter #(
        .MAX_WIDTH  (MAXW),
        .MAX_HEIGHT (MAXH)
    ) u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .command        (command),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .pixel_value    (pixel_value),
        .target_x       (target_x),
        .target_y       (target_y),
        .blit_width     (blit_width),
        .blit_height    (blit_height),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .read_pixel     (read_pixel),
        .pixels_written (pixels_written),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #60_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic int screen_dim(logic [6:0] r, int lim);
        return (int'(r) > lim) ? lim : int'(r);
    endfunction

    function automatic bit on_screen(int x, int y, int w, int h);
        return x >= 0 && y >= 0 && x < w && y < h;
    endfunction

    // Apply one item to the local screens and work out its result
    function automatic blit_result_t blit_predict(pix_item_t it);
        int           sw, sh, dw, dh;
        int           fx, fy, tx, ty, w, h;
        int           r, c, si, di;
        blit_result_t res;
        sw = screen_dim(size_reg[CFG_SRC_W], MAXW);
        sh = screen_dim(size_reg[CFG_SRC_H], MAXH);
        dw = screen_dim(size_reg[CFG_DST_W], MAXW);
        dh = screen_dim(size_reg[CFG_DST_H], MAXH);
        fx = it.px;
        fy = it.py;
        res.rd = '0;
        res.count = '0;
        case (it.cmd)
            CMD_LOAD_SRC:
                if (on_screen(fx, fy, sw, sh))
                    src_screen[fy * sw + fx] = it.val;
            CMD_LOAD_DST:
                if (on_screen(fx, fy, dw, dh))
                    dst_screen[fy * dw + fx] = it.val;
            CMD_READ:
                if (on_screen(fx, fy, dw, dh))
                    res.rd = dst_screen[fy * dw + fx];
            default:
            begin
                tx = it.tx;
                ty = it.ty;
                w = it.w;
                h = it.h;
                // negative source corner shifts the target, then the reverse
                if (fx < 0) begin tx -= fx; w += fx; fx = 0; end
                if (fy < 0) begin ty -= fy; h += fy; fy = 0; end
                if (tx < 0) begin fx -= tx; w += tx; tx = 0; end
                if (ty < 0) begin fy -= ty; h += ty; ty = 0; end
                if (fx + w > sw) w = sw - fx;
                if (tx + w > dw) w = dw - tx;
                if (fy + h > sh) h = sh - fy;
                if (ty + h > dh) h = dh - ty;
                if (w > 0 && h > 0)
                begin
                    for (r = 0; r < h; r++)
                    begin
                        for (c = 0; c < w; c++)
                        begin
                            si = (fy + r) * sw + fx + c;
                            di = (ty + r) * dw + tx + c;
                            if (si >= 0 && si < SCREEN && di >= 0 && di < SCREEN)
                                dst_screen[di] = dst_screen[di] | src_screen[si];
                        end
                    end
                    res.count = 13'(w * h);
                end
            end
        endcase
        return res;
    endfunction

    function automatic pix_item_t make_item(cmd_code_t cmd, int px, int py, int val = 0,
                                            int tx = 0, int ty = 0, int w = 0, int h = 0);
        pix_item_t it;
        it.cmd = cmd;
        it.px = px[8:0];
        it.py = py[8:0];
        it.val = val[7:0];
        it.tx = tx[8:0];
        it.ty = ty[8:0];
        it.w = w[8:0];
        it.h = h[8:0];
        return it;
    endfunction

    // Mostly near the top-left corner so reads find loaded pixels
    function automatic int rand_coord(int dim);
        int v;
        case ($urandom_range(0, 9))
            0: v = $urandom_range(0, 511);
            1: v = dim - 2 + int'($urandom_range(0, 3));
            2: v = -int'($urandom_range(1, 3));
            default: v = (dim > 0) ? int'($urandom_range(0, (dim < 16 ? dim : 16) - 1)) : 0;
        endcase
        return v;
    endfunction

    function automatic int rand_size();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(0, 511);
        return int'($urandom_range(0, 24)) - 4;
    endfunction

    function automatic pix_item_t rand_item();
        int        sw, sh, dw, dh, pick;
        cmd_code_t cmd;
        sw = screen_dim(size_reg[CFG_SRC_W], MAXW);
        sh = screen_dim(size_reg[CFG_SRC_H], MAXH);
        dw = screen_dim(size_reg[CFG_DST_W], MAXW);
        dh = screen_dim(size_reg[CFG_DST_H], MAXH);
        pick = $urandom_range(0, 9);
        if (pick < 3)
            cmd = CMD_LOAD_SRC;
        else if (pick < 5)
            cmd = CMD_LOAD_DST;
        else if (pick < 7)
            cmd = CMD_READ;
        else
            cmd = CMD_BLIT;
        if (cmd == CMD_LOAD_SRC || cmd == CMD_BLIT)
            return make_item(cmd, rand_coord(sw), rand_coord(sh), $urandom_range(0, 255),
                             rand_coord(dw), rand_coord(dh), rand_size(), rand_size());
        return make_item(cmd, rand_coord(dw), rand_coord(dh), $urandom_range(0, 255),
                         $urandom_range(0, 511), $urandom_range(0, 511),
                         $urandom_range(0, 511), $urandom_range(0, 511));
    endfunction

    task automatic send_item(pix_item_t it);
        @(negedge clk);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        item_valid  <= 1'b1;
        command     <= it.cmd;
        pos_x       <= it.px;
        pos_y       <= it.py;
        pixel_value <= it.val;
        target_x    <= it.tx;
        target_y    <= it.ty;
        blit_width  <= it.w;
        blit_height <= it.h;
        do @(posedge clk); while (item_stall);
        pending_results.push_back(blit_predict(it));
    endtask

    // Hold off until every outstanding result has come back
    task automatic wait_drained();
        @(negedge clk);
        item_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [6:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        size_reg[idx] = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_sizes(logic [6:0] sw, logic [6:0] sh, logic [6:0] dw, logic [6:0] dh);
        write_reg(CFG_SRC_W, sw);
        write_reg(CFG_SRC_H, sh);
        write_reg(CFG_DST_W, dw);
        write_reg(CFG_DST_H, dh);
    endtask

    task automatic test_pixel_access();
        send_item(make_item(CMD_LOAD_SRC, 0, 0, 8'hFF));
        send_item(make_item(CMD_LOAD_SRC, 63, 63, 8'hA5));
        send_item(make_item(CMD_LOAD_SRC, -1, 0, 8'h11));
        send_item(make_item(CMD_LOAD_SRC, 64, 5, 8'h22));
        send_item(make_item(CMD_LOAD_DST, 63, 0, 8'h0F));
        send_item(make_item(CMD_LOAD_DST, 0, 63, 8'h80));
        send_item(make_item(CMD_LOAD_DST, 255, -256, 8'h33));
        send_item(make_item(CMD_READ, 63, 0));
        send_item(make_item(CMD_READ, 0, 63));
        send_item(make_item(CMD_READ, -256, -256));
        send_item(make_item(CMD_READ, 64, 63));
    endtask

    task automatic test_blit_clipping();
        send_item(make_item(CMD_BLIT, 0, 0, 0, 0, 0, 255, 255));
        send_item(make_item(CMD_READ, 63, 63));
        send_item(make_item(CMD_BLIT, -3, -2, 0, 5, 5, 10, 10));
        send_item(make_item(CMD_BLIT, 2, 2, 0, -4, -1, 8, 8));
        send_item(make_item(CMD_BLIT, 60, 0, 0, 0, 60, 10, 10));
        send_item(make_item(CMD_BLIT, 0, 0, 0, 0, 0, -256, 5));
        send_item(make_item(CMD_BLIT, 0, 0, 0, 0, 0, 5, 0));
        send_item(make_item(CMD_BLIT, -256, -256, 0, 0, 0, 255, 255));
        send_item(make_item(CMD_READ, 5, 5));
    endtask

    task automatic test_size_extremes();
        wait_drained();
        // oversized registers act as the maximum
        write_sizes(7'd127, 7'd127, 7'd127, 7'd127);
        send_item(make_item(CMD_LOAD_SRC, 63, 63, 8'h5A));
        send_item(make_item(CMD_BLIT, 63, 63, 0, 0, 0, 2, 2));
        send_item(make_item(CMD_READ, 0, 0));
        wait_drained();
        // empty screens: loads dropped, reads zero, blits write nothing
        write_sizes(7'd0, 7'd64, 7'd64, 7'd0);
        send_item(make_item(CMD_LOAD_SRC, 0, 0, 8'h77));
        send_item(make_item(CMD_LOAD_DST, 0, 0, 8'h66));
        send_item(make_item(CMD_READ, 0, 0));
        send_item(make_item(CMD_BLIT, 0, 0, 0, 0, 0, 4, 4));
        wait_drained();
        write_sizes(7'd1, 7'd1, 7'd1, 7'd1);
        send_item(make_item(CMD_BLIT, 0, 0, 0, 0, 0, 3, 3));
        send_item(make_item(CMD_READ, 0, 0));
        wait_drained();
    endtask

    task automatic test_random_traffic();
        int phase, n;
        for (phase = 0; phase < N_PHASE; phase++)
        begin
            wait_drained();
            case (phase)
                0: write_sizes(7'd64, 7'd64, 7'd64, 7'd64);
                2: write_sizes(7'($urandom_range(1, 8)), 7'($urandom_range(1, 8)),
                               7'($urandom_range(1, 8)), 7'($urandom_range(1, 8)));
                3: write_sizes(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                               7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
                default: write_sizes(7'($urandom_range(1, 64)), 7'($urandom_range(1, 64)),
                                     7'($urandom_range(1, 64)), 7'($urandom_range(1, 64)));
            endcase
            // one phase runs flat out on both sides
            idle_on = (phase != 4);
            for (n = 0; n < 160; n++)
            begin
                if ($urandom_range(0, 99) == 0)
                    wait_drained();
                send_item(rand_item());
            end
        end
    endtask

    task automatic test_quiet_finish();
        int n;
        wait_drained();
        write_sizes(7'($urandom_range(1, 64)), 7'($urandom_range(1, 64)),
                    7'($urandom_range(1, 64)), 7'($urandom_range(1, 64)));
        idle_on = 1'b0;
        for (n = 0; n < 150; n++)
            send_item(rand_item());
    endtask

    // Receiver stalls in random bursts while idling is on
    initial
    begin
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 7);
            result_stall <= (stall_left > 0);
            if (stall_left > 0)
                stall_left--;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_results.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result item: read_pixel=%02h pixels_written=%0d",
                             read_pixel, pixels_written);
            end
            else
            begin
                want = pending_results.pop_front();
                if (read_pixel !== want.rd || pixels_written !== want.count)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display({"mismatch: read_pixel exp %02h got %02h, ",
                                  "pixels_written exp %0d got %0d"},
                                 want.rd, read_pixel, want.count, pixels_written);
                end
            end
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        command      = CMD_LOAD_SRC;
        pos_x        = '0;
        pos_y        = '0;
        pixel_value  = '0;
        target_x     = '0;
        target_y     = '0;
        blit_width   = '0;
        blit_height  = '0;
        result_stall = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_SRC_W;
        cfg_data     = '0;
        fail_count   = 0;
        idle_on      = 1'b1;
        for (int i = 0; i < SCREEN; i++)
        begin
            src_screen[i] = '0;
            dst_screen[i] = '0;
        end
        for (int i = 0; i < 4; i++)
            size_reg[i] = 7'd64;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_pixel_access();
        test_blit_clipping();
        test_size_extremes();
        test_random_traffic();
        test_quiet_finish();

        wait_drained();
        repeat (20) @(posedge clk);
        fail_count += pending_results.size();
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

### filelist.f
src/cob_pkg.sv
src/cob_ctrl.sv
src/cob_datapath.sv
src/clipped_or_blitter.sv
dv/clipped_or_blitter_tb.sv
